FILE: sv/hfr_pkg.sv
`timescale 1ns / 1ps

package hfr_pkg;

  localparam int MaxFrame = 1024;

  localparam logic [7:0]  FlagByte     = 8'h7E;
  localparam logic [7:0]  EscByte      = 8'h7D;
  localparam logic [7:0]  EscMask      = 8'h20;
  localparam logic [7:0]  NoFrame      = 8'hFF;
  localparam logic [15:0] FcsInit      = 16'hFFFF;
  localparam logic [15:0] FcsPoly      = 16'h8408;
  localparam logic [15:0] GoodResidual = 16'hF0B8;

  localparam logic [7:0] AddrOneReset   = 8'h03;
  localparam logic [7:0] AddrTwoReset   = 8'h05;
  localparam logic [7:0] AddrThreeReset = 8'h41;
  localparam logic [9:0] DetectLimitReset = 10'd10;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 10;
  localparam int LenW      = 10;

  typedef enum logic [1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_ABORT  = 2'd1,
    FUNC_DETECT = 2'd2,
    FUNC_PASS   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD      = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_FALLBACK = 3'd4,
    KIND_RAW      = 3'd5
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ADDR_ONE     = 2'd0,
    REG_ADDR_TWO     = 2'd1,
    REG_ADDR_THREE   = 2'd2,
    REG_DETECT_LIMIT = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0] addr_one;
    logic [7:0] addr_two;
    logic [7:0] addr_three;
    logic [9:0] detect_limit;
  } cfg_t;

  typedef struct packed {
    kind_e         kind;
    logic [7:0]    data;
    logic [7:0]    address;
    logic          ack_needed;
    logic [2:0]    ack_seq;
    logic [LenW-1:0] payload_length;
    logic [15:0]   fcs_residual;
  } result_t;

  // Reflected FCS-16, one byte, bit at a time (LSB first).
  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FcsPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/hfr_if.sv
`timescale 1ns / 1ps

interface hfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface hfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [7:0]  address;
  logic        ack_needed;
  logic [2:0]  ack_seq;
  logic [9:0]  payload_length;
  logic [15:0] fcs_residual;

  modport source (output valid, output kind, output data, output address, output ack_needed,
                  output ack_seq, output payload_length, output fcs_residual, input ready);
  modport sink   (input valid, input kind, input data, input address, input ack_needed,
                  input ack_seq, input payload_length, input fcs_residual, output ready);
endinterface

interface hfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

FILE: sv/hfr_deframer.sv
`timescale 1ns / 1ps

module hfr_deframer #(
  parameter int MAX_FRAME = hfr_pkg::MaxFrame
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       func_i,
  input  logic [7:0]       rx_byte_i,
  input  hfr_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output hfr_pkg::result_t res_o
);

  localparam int CntW = $clog2(MAX_FRAME + 1);
  localparam int CmpW = (CntW > hfr_pkg::LenW) ? CntW : hfr_pkg::LenW;

  typedef enum logic [1:0] {
    MODE_DETECT = 2'd0,
    MODE_HDLC   = 2'd1,
    MODE_PASS   = 2'd2
  } mode_e;

  mode_e            mode_q, mode_d;
  logic             esc_q, esc_d;
  logic [7:0]       addr_q, addr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      fcs_q, fcs_d;
  logic [7:0]       hold0_q, hold0_d;
  logic [7:0]       hold1_q, hold1_d;
  logic [7:0]       ctrl_q, ctrl_d;

  logic [7:0]       c;
  logic             frame_open;
  logic             addr_match;
  logic [15:0]      fcs_next;
  logic [CmpW-1:0]  len_w;
  hfr_pkg::func_e   func;

  assign func       = hfr_pkg::func_e'(func_i);
  assign c          = esc_q ? (rx_byte_i ^ hfr_pkg::EscMask) : rx_byte_i;
  assign frame_open = (addr_q != hfr_pkg::NoFrame);
  assign addr_match = (c != hfr_pkg::NoFrame) &&
                      ((c == cfg_i.addr_one) || (c == cfg_i.addr_two) ||
                       (c == cfg_i.addr_three));
  // address byte seeds from init, later bytes chain on the running value
  assign fcs_next   = hfr_pkg::fcs_update(frame_open ? fcs_q : hfr_pkg::FcsInit, c);
  assign len_w      = CmpW'(cnt_q) - CmpW'(3);

  always_comb begin
    mode_d  = mode_q;
    esc_d   = esc_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    fcs_d   = fcs_q;
    hold0_d = hold0_q;
    hold1_d = hold1_q;
    ctrl_d  = ctrl_q;
    res_valid_o = 1'b0;
    res_o   = '0;

    if (accept_i) begin
      unique case (func)
        hfr_pkg::FUNC_ABORT: begin
          esc_d   = 1'b0;
          addr_d  = hfr_pkg::NoFrame;
          cnt_d   = '0;
          fcs_d   = hfr_pkg::FcsInit;
          hold0_d = '0;
          hold1_d = '0;
        end
        hfr_pkg::FUNC_DETECT: mode_d = MODE_DETECT;
        hfr_pkg::FUNC_PASS:   mode_d = MODE_PASS;
        hfr_pkg::FUNC_DATA: begin
          if (mode_q == MODE_PASS) begin
            res_valid_o = 1'b1;
            res_o.kind  = hfr_pkg::KIND_RAW;
            res_o.data  = rx_byte_i;
          end else if (rx_byte_i == hfr_pkg::FlagByte) begin
            if (frame_open) begin
              res_valid_o        = 1'b1;
              res_o.address      = addr_q;
              res_o.fcs_residual = fcs_q;
              if (fcs_q == hfr_pkg::GoodResidual && cnt_q >= CntW'(3)) begin
                mode_d               = MODE_HDLC;
                res_o.kind           = hfr_pkg::KIND_GOOD;
                res_o.ack_needed     = ~ctrl_q[0];
                res_o.ack_seq        = ctrl_q[3:1];
                res_o.payload_length = len_w[hfr_pkg::LenW-1:0];
              end else begin
                res_o.kind = hfr_pkg::KIND_BAD;
              end
            end
            addr_d  = hfr_pkg::NoFrame;
            cnt_d   = '0;
            fcs_d   = hfr_pkg::FcsInit;
            hold0_d = '0;
            hold1_d = '0;
          end else if (rx_byte_i == hfr_pkg::EscByte) begin
            esc_d = 1'b1;
          end else begin
            esc_d = 1'b0;
            if (!frame_open) begin
              if (addr_match) begin
                addr_d  = c;
                cnt_d   = '0;
                fcs_d   = fcs_next;
                hold0_d = '0;
                hold1_d = '0;
              end
            end else if (mode_q != MODE_HDLC &&
                         CmpW'(cnt_q) > CmpW'(cfg_i.detect_limit)) begin
              // too long without a good frame: give up on HDLC
              mode_d        = MODE_PASS;
              res_valid_o   = 1'b1;
              res_o.kind    = hfr_pkg::KIND_FALLBACK;
              res_o.address = addr_q;
            end else if (cnt_q >= CntW'(MAX_FRAME)) begin
              addr_d        = hfr_pkg::NoFrame;
              cnt_d         = '0;
              fcs_d         = hfr_pkg::FcsInit;
              hold0_d       = '0;
              hold1_d       = '0;
              res_valid_o   = 1'b1;
              res_o.kind    = hfr_pkg::KIND_OVERFLOW;
              res_o.address = addr_q;
            end else begin
              if (cnt_q == '0) begin
                ctrl_d = c;
              end
              // two-byte delay keeps the FCS bytes from going out as payload
              if (cnt_q >= CntW'(3) && addr_q != cfg_i.addr_three) begin
                res_valid_o   = 1'b1;
                res_o.kind    = hfr_pkg::KIND_PAYLOAD;
                res_o.data    = hold0_q;
                res_o.address = addr_q;
              end
              hold0_d = hold1_q;
              hold1_d = c;
              fcs_d   = fcs_next;
              cnt_d   = cnt_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_DETECT;
      esc_q   <= 1'b0;
      addr_q  <= hfr_pkg::NoFrame;
      cnt_q   <= '0;
      fcs_q   <= hfr_pkg::FcsInit;
      hold0_q <= '0;
      hold1_q <= '0;
      ctrl_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      fcs_q   <= fcs_d;
      hold0_q <= hold0_d;
      hold1_q <= hold1_d;
      ctrl_q  <= ctrl_d;
    end
  end

endmodule

FILE: sv/hfr_out_buf.sv
`timescale 1ns / 1ps

module hfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hfr_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output hfr_pkg::result_t data_o
);

  hfr_pkg::result_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/hdlc_frame_receiver.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   func[1:0], rx_byte[7:0]
// out_ch    out  valid/ready   kind, data, address, ack_needed, ack_seq,
//                              payload_length, fcs_residual
// cfg_ch    in   valid/ready   index[1:0], value[9:0]
//
// One request per cycle while in_ch.ready is high; the whole byte step
// (unescape, address match, FCS-16 byte update, count checks) is
// combinational. A result is registered into a two-entry output buffer
// and shows on out_ch from there; in_ch.ready drops only while both
// entries wait. cfg_ch is always ready. Reset loads the default addresses
// and limit, detect mode, and no open frame.

module hdlc_frame_receiver #(
  parameter int MAX_FRAME = hfr_pkg::MaxFrame
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfr_in_if.sink    in_ch,
  hfr_out_if.source out_ch,
  hfr_cfg_if.sink   cfg_ch
);

  hfr_pkg::cfg_t    cfg_q;
  hfr_pkg::result_t res;
  hfr_pkg::result_t out_res;
  logic             res_valid;
  logic             buf_full;
  logic             in_accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ~buf_full;
  assign in_accept    = in_ch.valid && ~buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.addr_one     <= hfr_pkg::AddrOneReset;
      cfg_q.addr_two     <= hfr_pkg::AddrTwoReset;
      cfg_q.addr_three   <= hfr_pkg::AddrThreeReset;
      cfg_q.detect_limit <= hfr_pkg::DetectLimitReset;
    end else if (cfg_ch.valid) begin
      unique case (hfr_pkg::reg_e'(cfg_ch.index))
        hfr_pkg::REG_ADDR_ONE:     cfg_q.addr_one     <= cfg_ch.value[7:0];
        hfr_pkg::REG_ADDR_TWO:     cfg_q.addr_two     <= cfg_ch.value[7:0];
        hfr_pkg::REG_ADDR_THREE:   cfg_q.addr_three   <= cfg_ch.value[7:0];
        hfr_pkg::REG_DETECT_LIMIT: cfg_q.detect_limit <= cfg_ch.value;
        default: ;
      endcase
    end
  end

  hfr_deframer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .func_i      (in_ch.func),
    .rx_byte_i   (in_ch.rx_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_ch.ready),
    .full_o      (buf_full),
    .valid_o     (out_ch.valid),
    .data_o      (out_res)
  );

  assign out_ch.kind           = out_res.kind;
  assign out_ch.data           = out_res.data;
  assign out_ch.address        = out_res.address;
  assign out_ch.ack_needed     = out_res.ack_needed;
  assign out_ch.ack_seq        = out_res.ack_seq;
  assign out_ch.payload_length = out_res.payload_length;
  assign out_ch.fcs_residual   = out_res.fcs_residual;

endmodule

FILE: sv/hfr_checker.sv
`timescale 1ns / 1ps

module hfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_func_i,
  input logic        out_valid_i,
  input logic [2:0]  out_kind_i,
  input logic [7:0]  out_data_i,
  input logic [7:0]  out_address_i,
  input logic [15:0] out_fcs_residual_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // back-pressure only comes from results stuck in the buffer
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // a command into an empty buffer leaves it empty
  a_cmd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i && in_func_i != hfr_pkg::FUNC_DATA)
    |=> !out_valid_i)
    else $error("command produced a result");

  a_raw_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_kind_i == hfr_pkg::KIND_RAW)
    |-> (out_address_i == 8'h00 && out_fcs_residual_i == 16'h0000))
    else $error("raw byte with frame fields set");

  a_close_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_kind_i == hfr_pkg::KIND_GOOD || out_kind_i == hfr_pkg::KIND_BAD))
    |-> (out_data_i == 8'h00))
    else $error("frame close carries data");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write stalled");

endmodule

bind hdlc_frame_receiver hfr_checker u_hfr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_ch.valid),
  .in_ready_i         (in_ch.ready),
  .in_func_i          (in_ch.func),
  .out_valid_i        (out_ch.valid),
  .out_kind_i         (out_ch.kind),
  .out_data_i         (out_ch.data),
  .out_address_i      (out_ch.address),
  .out_fcs_residual_i (out_ch.fcs_residual),
  .cfg_valid_i        (cfg_ch.valid),
  .cfg_ready_i        (cfg_ch.ready)
);

FILE: tb/hdlc_frame_receiver_tb.sv
`timescale 1ns / 1ps

module hdlc_frame_receiver_tb;
  import hfr_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int StallLimit    = 3000;
  localparam int SettleCycles  = 4;
  localparam int PhaseItems    = 20;

  typedef enum logic [1:0] {
    LINK_DETECT = 2'd0,
    LINK_HDLC   = 2'd1,
    LINK_PASS   = 2'd2
  } link_mode_e;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_FCS,
    FRAME_OPEN
  } frame_flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hfr_in_if  in_ch ();
  hfr_out_if out_ch ();
  hfr_cfg_if cfg_ch ();

  hdlc_frame_receiver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the receiver state
  cfg_t        shadow_cfg;
  link_mode_e  link_mode;
  logic        esc_pending;
  logic [7:0]  open_addr;
  logic [10:0] frame_count;
  logic [15:0] fcs_acc;
  logic [7:0]  held [2];
  logic [7:0]  ctrl_seen;

  result_t     pending_reports[$];
  logic [7:0]  body_buf[$];

  int errors      = 0;
  int items_sent  = 0;
  int tx_idle_pct = 14;
  int rx_idle_pct = 14;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ FcsPoly;
      end
    end
    return r;
  endfunction

  function automatic void drop_frame();
    open_addr   = NoFrame;
    frame_count = '0;
    fcs_acc     = FcsInit;
    held[0]     = '0;
    held[1]     = '0;
  endfunction

  // one request through the deframer; returns 1 when it yields a result
  function automatic bit deframe_step(input func_e f, input logic [7:0] b, output result_t r);
    logic [7:0] c;
    bit         deliver;
    r = '0;
    c = b;
    case (f)
      FUNC_ABORT: begin
        esc_pending = 1'b0;
        drop_frame();
        return 1'b0;
      end
      FUNC_DETECT: begin
        link_mode = LINK_DETECT;
        return 1'b0;
      end
      FUNC_PASS: begin
        link_mode = LINK_PASS;
        return 1'b0;
      end
      default: ;
    endcase

    if (link_mode == LINK_PASS) begin
      r.kind = KIND_RAW;
      r.data = c;
      return 1'b1;
    end

    if (c == FlagByte) begin
      if (open_addr != NoFrame) begin
        r.address      = open_addr;
        r.fcs_residual = fcs_acc;
        if (fcs_acc == GoodResidual && frame_count >= 11'd3) begin
          link_mode        = LINK_HDLC;
          r.kind           = KIND_GOOD;
          r.ack_needed     = ~ctrl_seen[0];
          r.ack_seq        = ctrl_seen[3:1];
          r.payload_length = LenW'(frame_count - 11'd3);
        end else begin
          r.kind = KIND_BAD;
        end
        drop_frame();
        return 1'b1;
      end
      drop_frame();
      return 1'b0;
    end

    if (c == EscByte) begin
      esc_pending = 1'b1;
      return 1'b0;
    end
    if (esc_pending) begin
      c           = c ^ EscMask;
      esc_pending = 1'b0;
    end

    if (open_addr == NoFrame) begin
      if (c != NoFrame && (c == shadow_cfg.addr_one || c == shadow_cfg.addr_two ||
                           c == shadow_cfg.addr_three)) begin
        drop_frame();
        open_addr = c;
        fcs_acc   = crc16_byte(FcsInit, c);
      end
      return 1'b0;
    end

    if (link_mode != LINK_HDLC && frame_count > {1'b0, shadow_cfg.detect_limit}) begin
      link_mode = LINK_PASS;
      r.kind    = KIND_FALLBACK;
      r.address = open_addr;
      return 1'b1;
    end

    if (frame_count >= 11'(MaxFrame)) begin
      r.kind    = KIND_OVERFLOW;
      r.address = open_addr;
      drop_frame();
      return 1'b1;
    end

    if (frame_count == 11'd0) begin
      ctrl_seen = c;
    end
    // two bytes held back so the FCS never comes out as payload
    deliver = (frame_count >= 11'd3) && (open_addr != shadow_cfg.addr_three);
    if (deliver) begin
      r.kind    = KIND_PAYLOAD;
      r.data    = held[0];
      r.address = open_addr;
    end
    held[0]     = held[1];
    held[1]     = c;
    fcs_acc     = crc16_byte(fcs_acc, c);
    frame_count = frame_count + 11'd1;
    return deliver;
  endfunction

  task automatic send_request(input func_e f, input logic [7:0] b);
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (deframe_step(f, b, r)) begin
      pending_reports.push_back(r);
    end
  endtask

  task automatic send_data(input logic [7:0] b);
    send_request(FUNC_DATA, b);
  endtask

  // stuff flag and escape, and now and then escape a byte that does not need it
  task automatic send_escaped(input logic [7:0] b);
    bit must, may;
    must = (b == FlagByte) || (b == EscByte);
    may  = ((b ^ EscMask) != FlagByte) && ((b ^ EscMask) != EscByte);
    if (must || (may && $urandom_range(15) == 0)) begin
      send_data(EscByte);
      send_data(b ^ EscMask);
    end else begin
      send_data(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] addr, input frame_flaw_e flaw);
    logic [15:0] crc;
    logic [7:0]  wire_bytes[$];
    wire_bytes.push_back(addr);
    foreach (body_buf[i]) wire_bytes.push_back(body_buf[i]);
    crc = FcsInit;
    foreach (wire_bytes[i]) crc = crc16_byte(crc, wire_bytes[i]);
    crc = ~crc;
    if (flaw == FRAME_BAD_FCS) begin
      crc = crc ^ (16'h1 << $urandom_range(15));
    end
    wire_bytes.push_back(crc[7:0]);
    wire_bytes.push_back(crc[15:8]);
    send_data(FlagByte);
    foreach (wire_bytes[i]) send_escaped(wire_bytes[i]);
    if (flaw != FRAME_OPEN) begin
      send_data(FlagByte);
    end
  endtask

  task automatic fill_body(input int n);
    body_buf.delete();
    repeat (n) body_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_ADDR_ONE:     shadow_cfg.addr_one     = v[7:0];
      REG_ADDR_TWO:     shadow_cfg.addr_two     = v[7:0];
      REG_ADDR_THREE:   shadow_cfg.addr_three   = v[7:0];
      REG_DETECT_LIMIT: shadow_cfg.detect_limit = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] a1, input logic [7:0] a2, input logic [7:0] a3,
                           input logic [9:0] lim);
    settle();
    write_reg(REG_ADDR_ONE, {2'b00, a1});
    write_reg(REG_ADDR_TWO, {2'b00, a2});
    write_reg(REG_ADDR_THREE, {2'b00, a3});
    write_reg(REG_DETECT_LIMIT, lim);
  endtask

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(9))
      0, 1, 2: return shadow_cfg.addr_one;
      3, 4, 5: return shadow_cfg.addr_two;
      6, 7:    return shadow_cfg.addr_three;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_frame_basics();
    send_data(FlagByte);  // nothing open
    body_buf = '{8'h0E, FlagByte, EscByte};
    send_frame(AddrOneReset, FRAME_GOOD);  // I-frame, N(S)=7, stuffed payload
    body_buf = '{8'hFF};
    send_frame(AddrTwoReset, FRAME_GOOD);  // U-frame, empty payload
    body_buf = '{8'h00, 8'h01};
    send_frame(AddrThreeReset, FRAME_GOOD);  // checked but payload held
    body_buf = '{8'h10, 8'hAA};
    send_frame(AddrOneReset, FRAME_BAD_FCS);
    // too short to be good
    send_data(AddrTwoReset);
    send_data(8'h00);
    send_data(FlagByte);
    // unknown address bytes are dropped
    send_data(8'h22);
    send_data(8'h11);
    send_data(FlagByte);
    // escape survives the flag and unmasks the address
    send_data(EscByte);
    send_data(FlagByte);
    send_data(AddrOneReset ^ EscMask);
    send_data(8'h00);
    send_request(FUNC_ABORT, 8'h00);
    send_data(FlagByte);
  endtask

  task automatic test_modes();
    send_request(FUNC_PASS, 8'hFF);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(FlagByte);
    send_data(EscByte);
    send_request(FUNC_DETECT, 8'($urandom_range(255)));
    // zero limit: second frame byte falls back, frame stays open
    configure(AddrOneReset, AddrTwoReset, AddrThreeReset, 10'd0);
    send_data(FlagByte);
    send_data(AddrOneReset);
    send_data(8'h11);
    send_data(8'h22);
    send_data(8'h33);
    send_request(FUNC_DETECT, 8'h00);
    send_data(8'h44);
    send_request(FUNC_ABORT, 8'($urandom_range(255)));
    send_request(FUNC_DETECT, 8'h00);
    // all-ones address never opens a frame
    configure(NoFrame, 8'h00, 8'hFE, 10'd1023);
    send_data(FlagByte);
    send_data(NoFrame);
    send_data(8'h01);
    send_data(FlagByte);
    body_buf = '{8'h00};
    send_frame(8'h00, FRAME_GOOD);
    body_buf = '{8'h01};
    send_frame(8'hFE, FRAME_GOOD);
  endtask

  task automatic test_long_frames();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(AddrOneReset, AddrTwoReset, AddrThreeReset, 10'd1023);
    body_buf = '{8'h01};
    send_frame(shadow_cfg.addr_one, FRAME_GOOD);  // locks HDLC
    fill_body(1023);
    send_frame(shadow_cfg.addr_two, FRAME_GOOD);  // count overflow
    send_request(FUNC_ABORT, 8'h00);
    send_request(FUNC_DETECT, 8'h00);
    tx_idle_pct = 14;
    rx_idle_pct = 14;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_request(FUNC_PASS, 8'h00);
    repeat (20) send_data(8'($urandom_range(255)));
    send_request(FUNC_DETECT, 8'h00);
  endtask

  task automatic test_random_traffic();
    int         start;
    int         roll;
    int         n;
    logic [7:0] b;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(AddrOneReset, AddrTwoReset, AddrThreeReset, DetectLimitReset);
        1: configure(8'($urandom_range(254)), 8'($urandom_range(254)),
                     8'($urandom_range(254)), 10'($urandom_range(20)));
        2: configure(8'h00, 8'hFE, 8'($urandom_range(254)), 10'd1023);
        default: configure(8'($urandom_range(254)), 8'($urandom_range(254)),
                           8'($urandom_range(254)), 10'($urandom_range(5, 40)));
      endcase
      send_request(FUNC_DETECT, 8'($urandom_range(255)));
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          n = ($urandom_range(19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
          fill_body(n);
          roll = $urandom_range(99);
          send_frame(pick_addr(), (roll < 80) ? FRAME_GOOD :
                                  (roll < 92) ? FRAME_BAD_FCS : FRAME_OPEN);
        end else if (roll < 80) begin
          send_request(FUNC_DETECT, 8'($urandom_range(255)));
        end else if (roll < 82) begin
          send_request(FUNC_PASS, 8'($urandom_range(255)));
          repeat ($urandom_range(1, 5)) send_data(8'($urandom_range(255)));
          send_request(FUNC_DETECT, 8'($urandom_range(255)));
        end else if (roll < 86) begin
          send_request(FUNC_ABORT, 8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0) begin
              b = $urandom_range(1) ? FlagByte : EscByte;
            end else begin
              b = 8'($urandom_range(255));
            end
            send_data(b);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: kind %0d data %0h", out_ch.kind, out_ch.data);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_ch.kind));
        check_field("data", 16'(want.data), 16'(out_ch.data));
        check_field("address", 16'(want.address), 16'(out_ch.address));
        check_field("ack_needed", 16'(want.ack_needed), 16'(out_ch.ack_needed));
        check_field("ack_seq", 16'(want.ack_seq), 16'(out_ch.ack_seq));
        check_field("payload_length", 16'(want.payload_length),
                    16'(out_ch.payload_length));
        check_field("fcs_residual", want.fcs_residual, out_ch.fcs_residual);
      end
    end
  end

  // result sink; a hold-off request parks ready low for a counted stretch
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_DATA;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_ADDR_ONE;
    cfg_ch.value  = '0;

    shadow_cfg  = '{AddrOneReset, AddrTwoReset, AddrThreeReset, DetectLimitReset};
    link_mode   = LINK_DETECT;
    esc_pending = 1'b0;
    ctrl_seen   = '0;
    drop_frame();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_frame_basics();
    test_modes();
    test_long_frames();
    test_backpressure();
    test_random_traffic();
    settle();

    if (errors == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/hfr_pkg.sv
sv/hfr_if.sv
sv/hfr_deframer.sv
sv/hfr_out_buf.sv
sv/hdlc_frame_receiver.sv
sv/hfr_checker.sv
tb/hdlc_frame_receiver_tb.sv
